// ===== sv/bdm_pkg.sv =====
// Shared types and constants of the BGGR bilinear demosaic block.
// No dependencies; every other file of the block refers to it by scoped names.
package bdm_pkg;

   localparam int MAX_LINE = 1024;
   localparam int MAX_ROWS = 4096;

   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int COL_W    = $clog2(MAX_LINE);
   localparam int ROW_W    = $clog2(MAX_ROWS);

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   localparam logic REG_LINE_WIDTH   = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RESET   = 11'd320;
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd240;

   // One classified request travelling from the front end to the back end.
   typedef struct packed {
      logic [7:0]       sample;
      logic [COL_W-1:0] line_addr;
      logic             emit;
      logic             row_odd;
      logic             col_odd;
      logic             top;
      logic             bottom;
      logic             left;
      logic             right;
      logic             frame_end;
   } cmd_type;

endpackage

// ===== sv/bdm_front.sv =====
// Front end: accepts requests, tracks raster positions and classifies each pixel.
// Depends on bdm_pkg.
module bdm_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         restart,
   input  logic [bdm_pkg::WIDTH_W-1:0]  line_width,
   input  logic [bdm_pkg::HEIGHT_W-1:0] frame_height,
   input  logic                         push,
   input  logic                         req_mode,
   input  logic [7:0]                   req_raw_pixel,
   output logic                         full,
   input  logic                         q_full,
   output logic                         q_push,
   output bdm_pkg::cmd_type             q_cmd
);

   logic [bdm_pkg::WIDTH_W-1:0]  w_eff;
   logic [bdm_pkg::WIDTH_W-1:0]  w_masked;
   logic [bdm_pkg::HEIGHT_W-1:0] h_eff;
   logic [bdm_pkg::HEIGHT_W-1:0] h_masked;
   logic [bdm_pkg::COL_W-1:0]    w_last;
   logic [bdm_pkg::ROW_W-1:0]    h_last;

   logic [bdm_pkg::COL_W-1:0] in_col_ff, in_col_in;
   logic [bdm_pkg::ROW_W-1:0] in_row_ff, in_row_in;
   logic [bdm_pkg::COL_W-1:0] out_col_ff, out_col_in;
   logic [bdm_pkg::ROW_W-1:0] out_row_ff, out_row_in;
   logic [bdm_pkg::COL_W-1:0] lcol_ff, lcol_in;
   logic                      drain_ff, drain_in;

   logic accept, is_drain, shift, emit, last_out;

   always_comb begin
      w_masked = line_width & ~bdm_pkg::WIDTH_W'(1);
      if (w_masked < bdm_pkg::WIDTH_W'(4)) begin
         w_eff = bdm_pkg::WIDTH_W'(4);
      end else if (w_masked > bdm_pkg::WIDTH_W'(bdm_pkg::MAX_LINE)) begin
         w_eff = bdm_pkg::WIDTH_W'(bdm_pkg::MAX_LINE);
      end else begin
         w_eff = w_masked;
      end
      h_masked = frame_height & ~bdm_pkg::HEIGHT_W'(1);
      if (h_masked < bdm_pkg::HEIGHT_W'(2)) begin
         h_eff = bdm_pkg::HEIGHT_W'(2);
      end else if (h_masked > bdm_pkg::HEIGHT_W'(bdm_pkg::MAX_ROWS)) begin
         h_eff = bdm_pkg::HEIGHT_W'(bdm_pkg::MAX_ROWS);
      end else begin
         h_eff = h_masked;
      end
   end

   assign w_last = bdm_pkg::COL_W'(w_eff - bdm_pkg::WIDTH_W'(1));
   assign h_last = bdm_pkg::ROW_W'(h_eff - bdm_pkg::HEIGHT_W'(1));

   assign full     = q_full;
   assign accept   = push && !q_full;
   assign is_drain = (req_mode == bdm_pkg::MODE_DRAIN);
   assign shift    = accept && (is_drain ? drain_ff : !drain_ff);
   assign emit     = is_drain ||
                     ((in_row_ff != '0) &&
                      !((in_row_ff == bdm_pkg::ROW_W'(1)) && (in_col_ff == '0)));
   assign last_out = (out_row_ff == h_last) && (out_col_ff == w_last);

   always_comb begin
      q_push          = shift;
      q_cmd.sample    = req_raw_pixel;
      q_cmd.line_addr = lcol_ff;
      q_cmd.emit      = emit;
      q_cmd.row_odd   = out_row_ff[0];
      q_cmd.col_odd   = out_col_ff[0];
      q_cmd.top       = (out_row_ff == '0);
      q_cmd.bottom    = (out_row_ff == h_last);
      q_cmd.left      = (out_col_ff == '0);
      q_cmd.right     = (out_col_ff == w_last);
      q_cmd.frame_end = is_drain && last_out;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lcol_in    = lcol_ff;
      drain_in   = drain_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lcol_in    = '0;
         drain_in   = 1'b0;
      end else if (shift) begin
         lcol_in = (lcol_ff == w_last) ? '0 : lcol_ff + 1'b1;
         if (!is_drain) begin
            if (in_col_ff == w_last) begin
               in_col_in = '0;
               if (in_row_ff == h_last) begin
                  in_row_in = '0;
                  drain_in  = 1'b1;
               end else begin
                  in_row_in = in_row_ff + 1'b1;
               end
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
         end
         if (emit) begin
            if (is_drain && last_out) begin
               out_col_in = '0;
               out_row_in = '0;
               drain_in   = 1'b0;
            end else if (out_col_ff == w_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lcol_ff    <= '0;
         drain_ff   <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lcol_ff    <= lcol_in;
         drain_ff   <= drain_in;
      end
   end

endmodule

// ===== sv/bdm_queue.sv =====
// Four-entry queue of classified requests between the front and back ends.
// Depends on bdm_pkg.
module bdm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  bdm_pkg::cmd_type wr_data,
   output logic             q_full,
   input  logic             rd_en,
   output logic             rd_valid,
   output bdm_pkg::cmd_type rd_data
);

   bdm_pkg::cmd_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign q_full   = (count_ff == 3'd4);
   assign rd_valid = (count_ff != 3'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !q_full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {2'b00, do_wr} - {2'b00, do_rd};
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/bdm_back.sv =====
// Back end: two line stores, the 3x3 window, interpolation and the result register.
// Depends on bdm_pkg.
module bdm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  bdm_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             empty,
   input  logic             pop,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic             rsp_frame_end
);

   logic [7:0] middle_row_ff [bdm_pkg::MAX_LINE];
   logic [7:0] upper_row_ff  [bdm_pkg::MAX_LINE];

   logic             adv;
   logic             vb_ff, vc_ff, vd_ff, out_valid_ff;
   logic             vb_in, vc_in, vd_in, out_valid_in;
   bdm_pkg::cmd_type cmd_b_ff, cmd_c_ff, cmd_d_ff;
   logic [7:0]       rd1_ff, rd2_ff, rd1_c_ff;
   logic [7:0]       win_ff [3][3];

   logic [7:0] red_c, grn_c, blu_c;
   logic [9:0] diag_sum, orth_sum;
   logic [8:0] vert_sum, horz_sum, ul_sum, dr_sum;

   assign adv   = !out_valid_ff || pop;
   assign q_pop = adv && q_valid;
   assign empty = !out_valid_ff;

   // Line stores: each delays its input by one row of the current width.
   always_ff @(posedge clock) begin
      if (adv && q_valid) begin
         rd1_ff                         <= middle_row_ff[q_cmd.line_addr];
         middle_row_ff[q_cmd.line_addr] <= q_cmd.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vb_ff) begin
         rd2_ff                           <= upper_row_ff[cmd_b_ff.line_addr];
         upper_row_ff[cmd_b_ff.line_addr] <= rd1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd_b_ff <= q_cmd;
         cmd_c_ff <= cmd_b_ff;
         rd1_c_ff <= rd1_ff;
         cmd_d_ff <= cmd_c_ff;
         if (vc_ff) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= rd2_ff;
            win_ff[1][2] <= rd1_c_ff;
            win_ff[2][2] <= cmd_c_ff.sample;
         end
         if (vd_ff && cmd_d_ff.emit) begin
            rsp_red       <= red_c;
            rsp_green     <= grn_c;
            rsp_blue      <= blu_c;
            rsp_frame_end <= cmd_d_ff.frame_end;
         end
      end
   end

   // Window rows are above, center and below; columns left, center and right.
   always_comb begin
      diag_sum = 10'(win_ff[0][0]) + 10'(win_ff[0][2]) + 10'(win_ff[2][0]) + 10'(win_ff[2][2]);
      orth_sum = 10'(win_ff[0][1]) + 10'(win_ff[1][0]) + 10'(win_ff[1][2]) + 10'(win_ff[2][1]);
      vert_sum = 9'(win_ff[0][1]) + 9'(win_ff[2][1]);
      horz_sum = 9'(win_ff[1][0]) + 9'(win_ff[1][2]);
      dr_sum   = 9'(win_ff[1][2]) + 9'(win_ff[2][1]);
      ul_sum   = 9'(win_ff[1][0]) + 9'(win_ff[0][1]);
      unique case ({cmd_d_ff.row_odd, cmd_d_ff.col_odd})
         2'b00: begin
            blu_c = win_ff[1][1];
            if (!cmd_d_ff.top && !cmd_d_ff.left) begin
               red_c = diag_sum[9:2];
               grn_c = orth_sum[9:2];
            end else begin
               red_c = win_ff[2][2];
               grn_c = dr_sum[8:1];
            end
         end
         2'b01: begin
            grn_c = win_ff[1][1];
            if (!cmd_d_ff.top && !cmd_d_ff.right) begin
               red_c = vert_sum[8:1];
               blu_c = horz_sum[8:1];
            end else begin
               red_c = win_ff[2][1];
               blu_c = win_ff[1][0];
            end
         end
         2'b10: begin
            grn_c = win_ff[1][1];
            if (!cmd_d_ff.bottom && !cmd_d_ff.left) begin
               red_c = horz_sum[8:1];
               blu_c = vert_sum[8:1];
            end else begin
               red_c = win_ff[1][2];
               blu_c = win_ff[0][1];
            end
         end
         default: begin
            red_c = win_ff[1][1];
            if (!cmd_d_ff.bottom && !cmd_d_ff.right) begin
               grn_c = orth_sum[9:2];
               blu_c = diag_sum[9:2];
            end else begin
               grn_c = ul_sum[8:1];
               blu_c = win_ff[0][0];
            end
         end
      endcase
   end

   always_comb begin
      vb_in        = adv ? q_valid : vb_ff;
      vc_in        = adv ? vb_ff : vc_ff;
      vd_in        = adv ? vc_ff : vd_ff;
      out_valid_in = adv ? (vd_ff && cmd_d_ff.emit) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         vb_ff        <= vb_in;
         vc_ff        <= vc_in;
         vd_ff        <= vd_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== sv/bayer_bggr_to_rgb_demosaic_unit.sv =====
// Top level of the BGGR bilinear demosaic block: configuration registers and wiring.
// Depends on bdm_pkg, bdm_front, bdm_queue and bdm_back.
//
// Raw 8-bit BGGR samples enter in raster order, one request per clock while
// full is low, and one RGB result per clock leaves once the pipeline is primed
// while pop keeps up; the sustained rate is one request per cycle, set by the
// single write and read port of each line store, which is touched once per
// request. A pixel's result becomes available after the sample one row plus
// one pixel later has been pushed, then passes a four-stage back end (two line
// store reads, window shift, result register). After the last sample of a
// frame, push line_width+1 drain requests (mode 1); each releases one pending
// result and the final one carries frame_end. Pixel requests pushed while a
// drain is pending, and drain requests pushed when none is pending, are
// accepted and dropped. Writing either register restarts the frame; write only
// while the block is idle. The line stores need no clearing pass after reset.
module bayer_bggr_to_rgb_demosaic_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_mode,
   input  logic [7:0]  req_raw_pixel,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_frame_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [bdm_pkg::WIDTH_W-1:0]  line_width_ff, line_width_in;
   logic [bdm_pkg::HEIGHT_W-1:0] frame_height_ff, frame_height_in;
   logic                         cfg_write;

   logic             q_full, q_push, q_valid, q_pop;
   bdm_pkg::cmd_type front_cmd, head_cmd;

   // The register index is the word address; the low byte-offset bits are ignored.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      if (cfg_write) begin
         unique case (paddr[2])
            bdm_pkg::REG_LINE_WIDTH:   line_width_in   = pwdata[bdm_pkg::WIDTH_W-1:0];
            bdm_pkg::REG_FRAME_HEIGHT: frame_height_in = pwdata[bdm_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         bdm_pkg::REG_LINE_WIDTH:   prdata = 32'(line_width_ff);
         bdm_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= bdm_pkg::LINE_WIDTH_RESET;
         frame_height_ff <= bdm_pkg::FRAME_HEIGHT_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // The front end classifies each request and knows the frame geometry.
   bdm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .restart       (cfg_write),
      .line_width    (line_width_ff),
      .frame_height  (frame_height_ff),
      .push          (push),
      .req_mode      (req_mode),
      .req_raw_pixel (req_raw_pixel),
      .full          (full),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (front_cmd)
   );

   // The queue lets the front keep accepting while the result side stalls.
   bdm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (front_cmd),
      .q_full   (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (head_cmd)
   );

   // The back end owns the line stores, the window and the result register.
   bdm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (head_cmd),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
